@@ rtl/core/lsbi_pkg.sv @@
// ----------------------------------------------------------------------------
// lsbi_pkg: shared types and constants for the LSBI embedder
// Request codes, lane control and per-lane counter event structs.
// ----------------------------------------------------------------------------
package lsbi_pkg;

  localparam int CNT_W     = 32;  // pattern counter width
  localparam int CTL_BITS  = 4;   // control slots that carry the map
  localparam int PATTERNS  = 4;   // 2-bit patterns, bits 2..1
  localparam int NUM_LANES = 3;   // blue, green, red
  localparam int RED_LANE  = 2;
  localparam int SLOT_W    = 32;

  typedef enum logic [1:0] {
    REQ_START_ANALYSIS = 2'd0,
    REQ_ANALYZE        = 2'd1,
    REQ_START_EMBED    = 2'd2,
    REQ_EMBED          = 2'd3
  } lsbi_req_t;

  typedef struct packed {
    logic ctl_en;   // component takes a map bit
    logic ctl_bit;
    logic pay_en;   // component takes a payload bit
    logic pay_bit;
  } lsbi_lane_ctl_t;

  typedef struct packed {
    logic       hit;      // analysis counted this component
    logic       changed;  // LSB would change
    logic [1:0] pat;
  } lsbi_evt_t;

endpackage

@@ rtl/core/lsbi_lane.sv @@
// ----------------------------------------------------------------------------
// lsbi_lane: one color component slot
// Writes control or payload bits into the LSB, reports analysis events.
// ----------------------------------------------------------------------------
module lsbi_lane
  import lsbi_pkg::*;
(
  input  logic [7:0]      comp,
  input  lsbi_lane_ctl_t  ctl,
  input  logic            embed,
  input  logic [3:0]      map,
  output logic [7:0]      comp_out,
  output lsbi_evt_t       evt
);

  logic [1:0] pat;
  logic       inv;

  assign pat = comp[2:1];
  assign inv = map[pat];

  always_comb begin
    comp_out = comp;
    if (embed && ctl.ctl_en) begin
      comp_out = {comp[7:1], ctl.ctl_bit};
    end else if (embed && ctl.pay_en) begin
      comp_out = {comp[7:1], ctl.pay_bit ^ inv};
    end
  end

  assign evt.hit     = ctl.pay_en & ~embed;
  assign evt.changed = comp[0] ^ ctl.pay_bit;
  assign evt.pat     = pat;

endmodule

@@ rtl/core/lsbi_merge.sv @@
// ----------------------------------------------------------------------------
// lsbi_merge: pattern counter bank
// Merges lane events into saturating changed/unchanged counters, derives map.
// ----------------------------------------------------------------------------
module lsbi_merge
  import lsbi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  update,
  input  lsbi_evt_t             evt [NUM_LANES],
  output logic [PATTERNS-1:0]   map_cur,
  output logic [PATTERNS-1:0]   map_nxt
);

  logic [CNT_W-1:0] ch_r  [PATTERNS];
  logic [CNT_W-1:0] un_r  [PATTERNS];
  logic [CNT_W-1:0] ch_nxt [PATTERNS];
  logic [CNT_W-1:0] un_nxt [PATTERNS];
  logic [1:0]       inc_ch [PATTERNS];
  logic [1:0]       inc_un [PATTERNS];
  logic [CNT_W:0]   sum_ch [PATTERNS];
  logic [CNT_W:0]   sum_un [PATTERNS];

  always_comb begin
    for (int p = 0; p < PATTERNS; p++) begin
      inc_ch[p] = '0;
      inc_un[p] = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        if (evt[l].hit && (evt[l].pat == 2'(p))) begin
          if (evt[l].changed) begin
            inc_ch[p] = inc_ch[p] + 2'd1;
          end else begin
            inc_un[p] = inc_un[p] + 2'd1;
          end
        end
      end
      sum_ch[p] = {1'b0, ch_r[p]} + (CNT_W+1)'(inc_ch[p]);
      sum_un[p] = {1'b0, un_r[p]} + (CNT_W+1)'(inc_un[p]);
      if (clear) begin
        ch_nxt[p] = '0;
        un_nxt[p] = '0;
      end else if (update) begin
        // saturate at all ones
        ch_nxt[p] = sum_ch[p][CNT_W] ? '1 : sum_ch[p][CNT_W-1:0];
        un_nxt[p] = sum_un[p][CNT_W] ? '1 : sum_un[p][CNT_W-1:0];
      end else begin
        ch_nxt[p] = ch_r[p];
        un_nxt[p] = un_r[p];
      end
      map_nxt[p] = ch_nxt[p] > un_nxt[p];
      map_cur[p] = ch_r[p] > un_r[p];
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < PATTERNS; p++) begin
      if (!rst_n) begin
        ch_r[p] <= '0;
        un_r[p] <= '0;
      end else begin
        ch_r[p] <= ch_nxt[p];
        un_r[p] <= un_nxt[p];
      end
    end
  end

endmodule

@@ rtl/core/lsbi_stego_embedder.sv @@
// ----------------------------------------------------------------------------
// lsbi_stego_embedder: LSBI pattern-inversion LSB embedder, top level
// Two passes over a BGR pixel stream: analysis counts per-pattern LSB flips,
// embedding writes the 4-bit map, then payload bits with pattern inversion.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+-------------
//  in      | in_req_type, in_blue/green/red,         | in  | in_valid/in_ready
//          | in_next_bits                            |     |
//  out     | out_blue/green/red, out_bits_used,      | out | out_valid/out_ready
//          | out_map_value, out_finished             |     |
//  cfg     | cfg_data (payload bit count)            | in  | cfg_valid/cfg_ready
//
//  One request per cycle while in_ready is high; results are registered.
//  Slot walk, three lanes and the counter bank update together on accept, so
//  back-to-back requests see the state left by the previous one.
//  Result register plus skid register: a new request enters while a result
//  waits; in_ready drops only when both are full. cfg_ready is always high.
//  rst_n (sync, active low) clears counters, slot index, map, count, valid flags.
// ----------------------------------------------------------------------------
module lsbi_stego_embedder
  import lsbi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  input  logic [2:0]  in_next_bits,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [1:0]  out_bits_used,
  output logic [3:0]  out_map_value,
  output logic        out_finished,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] bits_used;
    logic [3:0] map_value;
    logic       finished;
  } lsbi_res_t;

  lsbi_req_t          req;
  logic               accept;
  logic               drain;
  logic               walk;
  logic               embed;

  // slot bookkeeping
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  total_r;          // payload count + control bits, saturated
  logic [SLOT_W:0]    total_sum;
  logic [3:0]         latched_r, latched_nxt;

  logic [SLOT_W:0]    lane_slot [NUM_LANES];
  logic               lane_live [NUM_LANES];  // slot still below the total
  logic               lane_ctl  [NUM_LANES];  // slot is a control slot
  lsbi_lane_ctl_t     ctl       [NUM_LANES];
  lsbi_evt_t          evt       [NUM_LANES];
  logic [7:0]         comp_in   [NUM_LANES];
  logic [7:0]         comp_out  [NUM_LANES];
  logic [1:0]         adv;
  logic [1:0]         used;

  logic [3:0]         map_cur, map_nxt;
  lsbi_res_t          res;

  // output stage
  lsbi_res_t          out_r, skid_r;
  logic               out_v_r, skid_v_r;

  assign req       = lsbi_req_t'(in_req_type);
  assign in_ready  = ~skid_v_r;
  assign accept    = in_valid & in_ready;
  assign drain     = out_v_r & out_ready;
  assign walk      = (req == REQ_ANALYZE) || (req == REQ_EMBED);
  assign embed     = (req == REQ_EMBED);
  assign cfg_ready = 1'b1;

  assign comp_in[0] = in_blue;
  assign comp_in[1] = in_green;
  assign comp_in[2] = in_red;

  // Lane k sits at slot_r + k. A lane only gets a live slot when every lane
  // before it consumed one, since slot_r + k < total implies the same for
  // smaller k. Red is a slot only while still in the control region.
  always_comb begin
    adv  = '0;
    used = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_slot[k]   = {1'b0, slot_r} + (SLOT_W+1)'(k);
      lane_live[k]   = walk && (lane_slot[k] < {1'b0, total_r});
      lane_ctl[k]    = lane_slot[k] < (SLOT_W+1)'(CTL_BITS);
      ctl[k].ctl_en  = lane_live[k] && lane_ctl[k];
      ctl[k].ctl_bit = latched_r[lane_slot[k][1:0]];
      ctl[k].pay_en  = lane_live[k] && !lane_ctl[k] && (k != RED_LANE);
      ctl[k].pay_bit = in_next_bits[used];
      if (ctl[k].ctl_en || ctl[k].pay_en) begin
        adv = adv + 2'd1;
      end
      if (ctl[k].pay_en) begin
        used = used + 2'd1;
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lsbi_lane u_lane (
      .comp     (comp_in[g]),
      .ctl      (ctl[g]),
      .embed    (embed),
      .map      (latched_r),
      .comp_out (comp_out[g]),
      .evt      (evt[g])
    );
  end

  lsbi_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (accept && (req == REQ_START_ANALYSIS)),
    .update  (accept && (req == REQ_ANALYZE)),
    .evt     (evt),
    .map_cur (map_cur),
    .map_nxt (map_nxt)
  );

  // next slot index and latched map
  always_comb begin
    slot_nxt    = slot_r;
    latched_nxt = latched_r;
    if (accept) begin
      case (req)
        REQ_START_ANALYSIS: slot_nxt = '0;
        REQ_START_EMBED: begin
          slot_nxt    = '0;
          latched_nxt = map_cur;
        end
        REQ_ANALYZE,
        REQ_EMBED:          slot_nxt = slot_r + SLOT_W'(adv);
        default:            slot_nxt = slot_r;
      endcase
    end
  end

  // result for the request at the input
  always_comb begin
    res.blue      = comp_out[0];
    res.green     = comp_out[1];
    res.red       = comp_out[2];
    res.bits_used = used;
    case (req)
      REQ_START_ANALYSIS,
      REQ_ANALYZE:     res.map_value = map_nxt;
      REQ_START_EMBED: res.map_value = map_cur;
      REQ_EMBED:       res.map_value = latched_r;
      default:         res.map_value = latched_r;
    endcase
    res.finished = slot_nxt >= total_r;
  end

  assign total_sum = {1'b0, cfg_data} + (SLOT_W+1)'(CTL_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      latched_r <= '0;
      total_r   <= SLOT_W'(CTL_BITS);
      out_v_r   <= 1'b0;
      skid_v_r  <= 1'b0;
    end else begin
      slot_r    <= slot_nxt;
      latched_r <= latched_nxt;
      if (cfg_valid && cfg_ready) begin
        total_r <= total_sum[SLOT_W] ? '1 : total_sum[SLOT_W-1:0];
      end
      // two-entry output: skid drains into the result register first
      if (drain) begin
        if (skid_v_r) begin
          out_r    <= skid_r;
          skid_v_r <= 1'b0;
        end else if (accept) begin
          out_r <= res;
        end else begin
          out_v_r <= 1'b0;
        end
      end else if (accept) begin
        if (out_v_r) begin
          skid_r   <= res;
          skid_v_r <= 1'b1;
        end else begin
          out_r   <= res;
          out_v_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid     = out_v_r;
  assign out_blue      = out_r.blue;
  assign out_green     = out_r.green;
  assign out_red       = out_r.red;
  assign out_bits_used = out_r.bits_used;
  assign out_map_value = out_r.map_value;
  assign out_finished  = out_r.finished;

  // skid entry is only ever filled behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid without result entry");

  // a pixel never carries more than two payload bits
  a_bits_used_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.bits_used != 2'd3))
    else $error("bits_used out of range");

  // start requests rewind the slot walk
  a_start_rewinds : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((req == REQ_START_ANALYSIS) || (req == REQ_START_EMBED)))
      |=> (slot_r == '0))
    else $error("slot index not cleared by start request");

  // otherwise the walk only moves forward, never wraps
  a_slot_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && ((req == REQ_START_ANALYSIS) || (req == REQ_START_EMBED)))
      |=> (slot_r >= $past(slot_r)))
    else $error("slot index moved backward");

endmodule
